// ----- rtl/core/uvr_pkg.sv -----
// Package for the UTF-8 validator with replacement character.
// Holds byte constants, the result slot type and the lead byte decoder.
// No dependencies.
package uvr_pkg;

  localparam int unsigned RUN_DEPTH = 6;

  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] LEAD_ED    = 8'hED;

  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_LO_E0 = 8'hA0;
  localparam logic [7:0] CONT_HI_ED = 8'h9F;
  localparam logic [7:0] CONT_LO_F0 = 8'h90;
  localparam logic [7:0] CONT_HI_F4 = 8'h8F;

  localparam logic [7:0] REPL_B0    = 8'hEF;
  localparam logic [7:0] REPL_B1    = 8'hBF;
  localparam logic [7:0] REPL_B2    = 8'hBD;

  typedef struct packed {
    logic [7:0] data;
    logic       repl;
  } slot_t;

  function automatic logic [2:0] lead_span(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b < ASCII_TOP) begin
      len = 3'd1;
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      len = 3'd2;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      len = 3'd3;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/utf8_validate_replace.sv -----
// An accepted byte is registered in the input register, then loaded into the result register.
// Throughput: one input byte per cycle while each byte yields at most one result and
// the output is not stalled; a byte that yields more than one result holds the next
// byte until its last result is taken from the six-slot result register.
// Reset: asynchronous, active low; clears held sequence, error flag and both valids.
// Top level of the UTF-8 validator; depends on uvr_pkg.
module utf8_validate_replace (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_replacement_o,
  output logic       last_of_run_o,
  output logic       stream_end_o,
  output logic       stream_valid_o
);
  import uvr_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;
  logic        in_xfer;
  logic        out_xfer;
  logic        load;

  logic [7:0]  hb_q [3];
  logic [7:0]  hb_d [3];
  logic [1:0]  hc_q, hc_d;
  logic [2:0]  exp_q, exp_d;
  logic        err_q, err_d;

  slot_t       run_q [RUN_DEPTH];
  slot_t       run_d [RUN_DEPTH];
  logic [2:0]  rem_q, rem_d;
  logic [2:0]  n;
  logic        run_eos_q;
  logic        run_ok_q, run_ok_d;

  logic [7:0]  lo, hi;
  logic        cont_ok;
  logic        as_lead;
  logic [2:0]  len;

  assign out_valid_o = rem_q != 3'd0;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign load        = in_vld_q && ((rem_q == 3'd0) || (rem_q == 3'd1 && out_xfer));
  assign in_stall_o  = in_vld_q && !load;
  assign in_xfer     = in_valid_i && !in_stall_o;

  assign out_byte_o       = run_q[0].data;
  assign is_replacement_o = run_q[0].repl;
  assign last_of_run_o    = rem_q == 3'd1;
  assign stream_end_o     = (rem_q == 3'd1) && run_eos_q;
  assign stream_valid_o   = (rem_q == 3'd1) && run_eos_q && run_ok_q;

  always_comb begin
    hb_d  = hb_q;
    hc_d  = hc_q;
    exp_d = exp_q;
    err_d = err_q;
    n     = 3'd0;
    for (int i = 0; i < RUN_DEPTH; i++) begin
      run_d[i] = '{data: 8'h00, repl: 1'b0};
    end

    lo = CONT_LO;
    hi = CONT_HI;
    if (hc_q == 2'd1) begin
      case (hb_q[0])
        LEAD3_LO: lo = CONT_LO_E0;
        LEAD_ED:  hi = CONT_HI_ED;
        LEAD4_LO: lo = CONT_LO_F0;
        LEAD4_HI: hi = CONT_HI_F4;
        default:  ;
      endcase
    end
    cont_ok = (in_byte_q >= lo) && (in_byte_q <= hi);
    as_lead = (hc_q == 2'd0) || !cont_ok;
    len     = lead_span(in_byte_q);

    // replace the broken prefix, then retry the byte as a lead
    if (hc_q != 2'd0 && !cont_ok) begin
      run_d[n] = '{data: REPL_B0, repl: 1'b1};
      n = n + 3'd1;
      run_d[n] = '{data: REPL_B1, repl: 1'b1};
      n = n + 3'd1;
      run_d[n] = '{data: REPL_B2, repl: 1'b1};
      n = n + 3'd1;
      err_d = 1'b1;
    end

    if (as_lead) begin
      hc_d  = 2'd0;
      exp_d = 3'd0;
      if (len == 3'd1) begin
        run_d[n] = '{data: in_byte_q, repl: 1'b0};
        n = n + 3'd1;
      end else if (len == 3'd0) begin
        run_d[n] = '{data: REPL_B0, repl: 1'b1};
        n = n + 3'd1;
        run_d[n] = '{data: REPL_B1, repl: 1'b1};
        n = n + 3'd1;
        run_d[n] = '{data: REPL_B2, repl: 1'b1};
        n = n + 3'd1;
        err_d = 1'b1;
      end else begin
        hb_d[0] = in_byte_q;
        hc_d    = 2'd1;
        exp_d   = len;
      end
    end else if (({1'b0, hc_q} + 3'd1 >= exp_q) || (hc_q == 2'd3)) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(hc_q)) begin
          run_d[n] = '{data: hb_q[k], repl: 1'b0};
          n = n + 3'd1;
        end
      end
      run_d[n] = '{data: in_byte_q, repl: 1'b0};
      n = n + 3'd1;
      hc_d  = 2'd0;
      exp_d = 3'd0;
    end else begin
      case (hc_q)
        2'd1:    hb_d[1] = in_byte_q;
        2'd2:    hb_d[2] = in_byte_q;
        default: ;
      endcase
      hc_d = hc_q + 2'd1;
    end

    // cut-off sequence at end of stream
    if (in_eos_q && hc_d != 2'd0) begin
      run_d[n] = '{data: REPL_B0, repl: 1'b1};
      n = n + 3'd1;
      run_d[n] = '{data: REPL_B1, repl: 1'b1};
      n = n + 3'd1;
      run_d[n] = '{data: REPL_B2, repl: 1'b1};
      n = n + 3'd1;
      err_d = 1'b1;
      hc_d  = 2'd0;
      exp_d = 3'd0;
    end

    run_ok_d = !err_d;
    if (in_eos_q) begin
      err_d = 1'b0;
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = n;
    end else if (out_xfer) begin
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      hc_q      <= 2'd0;
      exp_q     <= 3'd0;
      err_q     <= 1'b0;
      rem_q     <= 3'd0;
      run_eos_q <= 1'b0;
      run_ok_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        hc_q      <= hc_d;
        exp_q     <= exp_d;
        err_q     <= err_d;
        run_eos_q <= in_eos_q;
        run_ok_q  <= run_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_byte_i;
      in_eos_q  <= end_of_stream_i;
    end
    if (load) begin
      hb_q  <= hb_d;
      run_q <= run_d;
    end else if (out_xfer) begin
      for (int i = 0; i < RUN_DEPTH - 1; i++) begin
        run_q[i] <= run_q[i + 1];
      end
    end
  end

`ifndef ASSERT_OFF
  a_held_below_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hc_q != 2'd0) |-> ({1'b0, hc_q} < exp_q))
    else $error("held count not below expected length");

  a_repl_not_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_replacement_o && out_byte_o == REPL_B0) |-> (rem_q >= 3'd3))
    else $error("replacement character split across loads");

  a_eos_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_eos_q) |=> (hc_q == 2'd0 && !err_q))
    else $error("state not cleared at end of stream");
`endif

endmodule
